FILE: hw/rtl/rs485rtu_pkg.sv
`default_nettype none
package rs485rtu_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TURN,
      PH_TX,
      PH_FIRST,
      PH_RX
   } phase_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_MUL,
      SQ_DIV,
      SQ_PUT
   } seq_type;

   localparam logic [2:0] MODE_START   = 3'd0;
   localparam logic [2:0] MODE_TICK    = 3'd1;
   localparam logic [2:0] MODE_TX_DONE = 3'd2;
   localparam logic [2:0] MODE_RX_BYTE = 3'd3;
   localparam logic [2:0] MODE_ERROR   = 3'd4;

   localparam logic [1:0] RES_OK      = 2'd0;
   localparam logic [1:0] RES_UART    = 2'd1;
   localparam logic [1:0] RES_TIMEOUT = 2'd2;

   localparam logic [1:0] CSR_BAUD    = 2'd0;
   localparam logic [1:0] CSR_FORMAT  = 2'd1;
   localparam logic [1:0] CSR_RESP_TO = 2'd2;

   localparam logic [22:0] TX_MARGIN_US   = 23'd500000;
   localparam logic [22:0] FRAME_LIMIT_US = 23'd5000000;
   localparam logic [14:0] TURN_US        = 15'd50;
   localparam logic [14:0] US_PER_MS      = 15'd1000;
   localparam logic [19:0] US_PER_S       = 20'd1000000;
   localparam int unsigned DIV_STEPS      = 33;

   typedef struct packed {
      logic       driver_enable;
      logic       start_transmit;
      logic       abort_uart;
      logic       byte_valid;
      logic [7:0] byte_index;
      logic [7:0] byte_data;
      logic       done_res;
      logic [1:0] result_code;
      logic [8:0] receive_length;
   } rsp_type;

   function automatic logic [16:0] baud_hz(input logic [2:0] sel);
      logic [16:0] r;
      case (sel)
         3'd0:    r = 17'd1200;
         3'd1:    r = 17'd2400;
         3'd2:    r = 17'd4800;
         3'd3:    r = 17'd9600;
         3'd4:    r = 17'd19200;
         3'd5:    r = 17'd38400;
         3'd6:    r = 17'd57600;
         default: r = 17'd115200;
      endcase
      return r;
   endfunction

   // t3.5 character silence in us
   function automatic logic [14:0] t35_us(input logic [2:0] sel);
      logic [14:0] r;
      case (sel)
         3'd0:    r = 15'd32084;
         3'd1:    r = 15'd16042;
         3'd2:    r = 15'd8021;
         3'd3:    r = 15'd4011;
         3'd4:    r = 15'd2006;
         default: r = 15'd1750;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rs485_rtu_master_transaction_core.sv
// rs485 rtu master transaction controller, timed in microsecond beats
// req channel: one event beat per item (start, us tick, transmit done,
//    byte received, uart error) with request length and received byte
// rsp channel: exactly one beat per request beat, carrying driver enable,
//    start/abort pulses, the emitted response byte and the done status
// csr port: baud select, frame format and response timeout, written while idle
// a start beat is latched, its length is multiplied, the restoring
//    divider works out the transmit timeout, and the result is then
//    handed over; every other beat goes from the latch straight to the
//    hand-over. one item is in flight at a time, req_stall stays high
//    while it is worked on
// the response sits in an output register, so the next request beat is taken
//    while an earlier response is still stalled; a finished result then waits
//    in a holding register until the output register frees up
// reset (synchronous, active high) returns to idle with the default
//    configuration: 9600 baud, 8n1, 1000 ms response timeout
`default_nettype none
module rs485_rtu_master_transaction_core
   import rs485rtu_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_mode,
   input  wire logic [8:0]  req_request_length,
   input  wire logic [7:0]  req_rx_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_driver_enable,
   output logic             rsp_start_transmit,
   output logic             rsp_abort_uart,
   output logic             rsp_byte_valid,
   output logic [7:0]       rsp_byte_index,
   output logic [7:0]       rsp_byte_data,
   output logic             rsp_done_res,
   output logic [1:0]       rsp_result_code,
   output logic [8:0]       rsp_receive_length,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   localparam logic [8:0] FullCount = 9'(MAX_FRAME_BYTES);

   // configuration
   logic [2:0]  baud_ff;
   logic [1:0]  format_ff;
   logic [15:0] resp_to_ff;

   // transaction state
   phase_type   phase_ff, phase_in;
   logic [22:0] deadline_ff, deadline_in;
   logic [14:0] silence_ff, silence_in;
   logic [8:0]  count_ff, count_in;
   logic        full_ff, full_in;

   // sequencer and divider
   seq_type     seq_ff, seq_in;
   logic [12:0] lenbits_ff;
   logic [32:0] num_ff;
   logic [16:0] rem_ff;
   logic [22:0] quot_ff;
   logic [5:0]  step_ff;

   rsp_type     res_ff, res_in;
   rsp_type     out_ff;
   logic        rsp_valid_ff;

   logic        req_fire;
   logic        out_free;
   logic        is_start;
   logic [17:0] rem_sh;
   logic        rem_ge;
   logic [16:0] baud;
   logic [14:0] sil_dec;
   logic [22:0] dl_dec;
   logic [14:0] sil_inc;
   logic [8:0]  count_nx;
   logic        div_last;

   assign req_fire = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_start = (req_mode == MODE_START) && (phase_ff == PH_IDLE);
   assign baud     = baud_hz(baud_ff);
   assign div_last = (step_ff == 6'(DIV_STEPS - 1));

   // one restoring division step per cycle
   assign rem_sh = {rem_ff, num_ff[32]};
   assign rem_ge = rem_sh >= {1'b0, baud};

   assign sil_dec  = (silence_ff != 15'd0) ? silence_ff - 15'd1 : silence_ff;
   assign dl_dec   = (deadline_ff != 23'd0) ? deadline_ff - 23'd1 : deadline_ff;
   assign sil_inc  = silence_ff + 15'd1;
   assign count_nx = count_ff + 9'd1;

   // sequencer next state
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SQ_IDLE: if (req_fire) seq_in = is_start ? SQ_MUL : SQ_PUT;
         SQ_MUL:  seq_in = SQ_DIV;
         SQ_DIV:  if (div_last) seq_in = SQ_PUT;
         SQ_PUT:  if (out_free) seq_in = SQ_IDLE;
         default: seq_in = SQ_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = (seq_ff != SQ_IDLE);
   end

   // event handling, applied on the accepted beat
   always_comb begin
      phase_in    = phase_ff;
      deadline_in = deadline_ff;
      silence_in  = silence_ff;
      count_in    = count_ff;
      full_in     = full_ff;
      res_in      = res_ff;
      if (seq_ff == SQ_IDLE && req_fire) begin
         res_in = '0;
         case (req_mode)
            MODE_START: begin
               if (phase_ff == PH_IDLE) begin
                  phase_in   = PH_TURN;
                  silence_in = TURN_US;
               end
            end
            MODE_TICK: begin
               case (phase_ff)
                  PH_TURN: begin
                     silence_in = sil_dec;
                     if (sil_dec == 15'd0) begin
                        phase_in              = PH_TX;
                        res_in.start_transmit = 1'b1;
                     end
                  end
                  PH_TX: begin
                     deadline_in = dl_dec;
                     if (dl_dec == 23'd0) begin
                        phase_in           = PH_IDLE;
                        res_in.abort_uart  = 1'b1;
                        res_in.done_res    = 1'b1;
                        res_in.result_code = RES_UART;
                     end
                  end
                  PH_FIRST: begin
                     silence_in = sil_inc;
                     // millisecond prescaler rolls over
                     if (sil_inc >= US_PER_MS) begin
                        silence_in  = 15'd0;
                        deadline_in = dl_dec;
                        if (dl_dec == 23'd0) begin
                           phase_in           = PH_IDLE;
                           res_in.abort_uart  = 1'b1;
                           res_in.done_res    = 1'b1;
                           res_in.result_code = RES_TIMEOUT;
                        end
                     end
                  end
                  PH_RX: begin
                     silence_in  = sil_dec;
                     deadline_in = dl_dec;
                     // silence end wins over the frame limit
                     if (sil_dec == 15'd0) begin
                        phase_in              = PH_IDLE;
                        res_in.abort_uart     = 1'b1;
                        res_in.done_res       = 1'b1;
                        res_in.result_code    = RES_OK;
                        res_in.receive_length = count_ff;
                     end else if (dl_dec == 23'd0) begin
                        phase_in           = PH_IDLE;
                        res_in.abort_uart  = 1'b1;
                        res_in.done_res    = 1'b1;
                        res_in.result_code = RES_UART;
                     end
                  end
                  default: ;
               endcase
            end
            MODE_TX_DONE: begin
               if (phase_ff == PH_TX) begin
                  count_in    = 9'd0;
                  full_in     = 1'b0;
                  silence_in  = 15'd0;
                  deadline_in = 23'(resp_to_ff);
                  if (resp_to_ff == 16'd0) begin
                     phase_in           = PH_IDLE;
                     res_in.abort_uart  = 1'b1;
                     res_in.done_res    = 1'b1;
                     res_in.result_code = RES_TIMEOUT;
                  end else begin
                     phase_in = PH_FIRST;
                  end
               end
            end
            MODE_RX_BYTE: begin
               if ((phase_ff == PH_FIRST || phase_ff == PH_RX) && !full_ff) begin
                  if (phase_ff == PH_FIRST) begin
                     phase_in    = PH_RX;
                     deadline_in = FRAME_LIMIT_US;
                  end
                  res_in.byte_valid = 1'b1;
                  res_in.byte_index = count_ff[7:0];
                  res_in.byte_data  = req_rx_data;
                  count_in          = count_nx;
                  if (count_nx >= FullCount) full_in = 1'b1;
                  silence_in = t35_us(baud_ff);
               end
            end
            MODE_ERROR: begin
               if (phase_ff == PH_TX) begin
                  phase_in           = PH_IDLE;
                  res_in.done_res    = 1'b1;
                  res_in.result_code = RES_UART;
               end else if (phase_ff == PH_FIRST || phase_ff == PH_RX) begin
                  phase_in           = PH_IDLE;
                  res_in.abort_uart  = 1'b1;
                  res_in.done_res    = 1'b1;
                  res_in.result_code = RES_UART;
               end
            end
            default: ;
         endcase
         res_in.driver_enable = (phase_in == PH_TURN) || (phase_in == PH_TX);
      end else if (seq_ff == SQ_DIV && div_last) begin
         // transmit timeout = ceil(len*bits*1e6/baud) + margin, 23 bits kept
         deadline_in = {quot_ff[21:0], rem_ge} + TX_MARGIN_US;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baud_ff    <= 3'd3;
         format_ff  <= 2'd0;
         resp_to_ff <= 16'd1000;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BAUD:    baud_ff    <= csr_write_data[2:0];
            CSR_FORMAT:  format_ff  <= csr_write_data[1:0];
            CSR_RESP_TO: resp_to_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SQ_IDLE;
         phase_ff     <= PH_IDLE;
         deadline_ff  <= '0;
         silence_ff   <= '0;
         count_ff     <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff      <= seq_in;
         phase_ff    <= phase_in;
         deadline_ff <= deadline_in;
         silence_ff  <= silence_in;
         count_ff    <= count_in;
         full_ff     <= full_in;
         if (seq_ff == SQ_PUT && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload and divider datapath
   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (seq_ff == SQ_PUT && out_free) out_ff <= res_ff;
      case (seq_ff)
         SQ_IDLE: begin
            lenbits_ff <= 13'(req_request_length) *
                          ((format_ff == 2'd0) ? 13'd10 : 13'd11);
         end
         SQ_MUL: begin
            num_ff  <= 33'(lenbits_ff) * 33'(US_PER_S) + 33'(baud) - 33'd1;
            rem_ff  <= '0;
            quot_ff <= '0;
            step_ff <= '0;
         end
         SQ_DIV: begin
            num_ff  <= {num_ff[31:0], 1'b0};
            rem_ff  <= rem_ge ? 17'(rem_sh - {1'b0, baud}) : rem_sh[16:0];
            quot_ff <= {quot_ff[21:0], rem_ge};
            step_ff <= step_ff + 6'd1;
         end
         default: ;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_driver_enable  = out_ff.driver_enable;
   assign rsp_start_transmit = out_ff.start_transmit;
   assign rsp_abort_uart     = out_ff.abort_uart;
   assign rsp_byte_valid     = out_ff.byte_valid;
   assign rsp_byte_index     = out_ff.byte_index;
   assign rsp_byte_data      = out_ff.byte_data;
   assign rsp_done_res       = out_ff.done_res;
   assign rsp_result_code    = out_ff.result_code;
   assign rsp_receive_length = out_ff.receive_length;

   // an accepted beat always leaves the sequencer busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> seq_ff != SQ_IDLE)
      else $error("sequencer stayed idle after accept");

   // a new response only appears from the hand-over step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(seq_ff == SQ_PUT))
      else $error("response raised outside hand-over");

   // a finished transaction never leaves the driver on
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_driver_enable)
      else $error("driver enabled on done");

   // a byte beat never closes the transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_done_res)
      else $error("byte and done together");

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

import rs485rtu_pkg::*;

// expected response beats, worked out from the events the block has accepted
class rtu_scoreboard;
   rsp_type     expected_rsp[$];
   logic [2:0]  baud_sel = 3'd3;
   logic [1:0]  char_fmt = 2'd0;
   logic [15:0] resp_ms = 16'd1000;
   phase_type   phase = PH_IDLE;
   logic [22:0] deadline = '0;
   logic [14:0] silence = '0;
   logic [8:0]  rx_count = '0;
   bit          full = 1'b0;

   function void write_csr(logic [1:0] idx, logic [15:0] value);
      case (idx)
         CSR_BAUD:    baud_sel = value[2:0];
         CSR_FORMAT:  char_fmt = value[1:0];
         CSR_RESP_TO: resp_ms = value;
         default: ;
      endcase
   endfunction

   function logic [14:0] silence_us();
      case (baud_sel)
         3'd0:    return 15'd32084;
         3'd1:    return 15'd16042;
         3'd2:    return 15'd8021;
         3'd3:    return 15'd4011;
         3'd4:    return 15'd2006;
         default: return 15'd1750;
      endcase
   endfunction

   function logic [22:0] tx_limit_us(logic [8:0] len);
      longint unsigned bits, baud, t;
      bits = (char_fmt == 2'd0) ? 10 : 11;
      case (baud_sel)
         3'd0:    baud = 1200;
         3'd1:    baud = 2400;
         3'd2:    baud = 4800;
         3'd3:    baud = 9600;
         3'd4:    baud = 19200;
         3'd5:    baud = 38400;
         3'd6:    baud = 57600;
         default: baud = 115200;
      endcase
      t = (longint'(len) * bits * 1000000 + baud - 1) / baud + 500000;
      return t[22:0];
   endfunction

   function void note_item(logic [2:0] mode, logic [8:0] len, logic [7:0] data);
      rsp_type r;
      r = '0;
      case (mode)
         MODE_START:
            if (phase == PH_IDLE) begin
               phase = PH_TURN;
               silence = 15'd50;
               deadline = tx_limit_us(len);
            end
         MODE_TICK:
            case (phase)
               PH_TURN: begin
                  if (silence != 0) silence--;
                  if (silence == 0) begin
                     phase = PH_TX;
                     r.start_transmit = 1'b1;
                  end
               end
               PH_TX: begin
                  if (deadline != 0) deadline--;
                  if (deadline == 0) begin
                     phase = PH_IDLE;
                     r.abort_uart = 1'b1;
                     r.done_res = 1'b1;
                     r.result_code = RES_UART;
                  end
               end
               PH_FIRST: begin
                  silence++;
                  if (silence >= 15'd1000) begin
                     silence = '0;
                     if (deadline != 0) deadline--;
                     if (deadline == 0) begin
                        phase = PH_IDLE;
                        r.abort_uart = 1'b1;
                        r.done_res = 1'b1;
                        r.result_code = RES_TIMEOUT;
                     end
                  end
               end
               PH_RX: begin
                  if (silence != 0) silence--;
                  if (deadline != 0) deadline--;
                  // silence end beats the frame limit on the same tick
                  if (silence == 0) begin
                     phase = PH_IDLE;
                     r.abort_uart = 1'b1;
                     r.done_res = 1'b1;
                     r.result_code = RES_OK;
                     r.receive_length = rx_count;
                  end else if (deadline == 0) begin
                     phase = PH_IDLE;
                     r.abort_uart = 1'b1;
                     r.done_res = 1'b1;
                     r.result_code = RES_UART;
                  end
               end
               default: ;
            endcase
         MODE_TX_DONE:
            if (phase == PH_TX) begin
               rx_count = '0;
               full = 1'b0;
               silence = '0;
               deadline = 23'(resp_ms);
               if (deadline == 0) begin
                  phase = PH_IDLE;
                  r.abort_uart = 1'b1;
                  r.done_res = 1'b1;
                  r.result_code = RES_TIMEOUT;
               end else begin
                  phase = PH_FIRST;
               end
            end
         MODE_RX_BYTE:
            if ((phase == PH_FIRST || phase == PH_RX) && !full) begin
               if (phase == PH_FIRST) begin
                  phase = PH_RX;
                  deadline = 23'd5000000;
               end
               r.byte_valid = 1'b1;
               r.byte_index = rx_count[7:0];
               r.byte_data = data;
               rx_count++;
               if (rx_count >= 9'd256) full = 1'b1;
               silence = silence_us();
            end
         MODE_ERROR:
            if (phase == PH_TX) begin
               phase = PH_IDLE;
               r.done_res = 1'b1;
               r.result_code = RES_UART;
            end else if (phase == PH_FIRST || phase == PH_RX) begin
               phase = PH_IDLE;
               r.abort_uart = 1'b1;
               r.done_res = 1'b1;
               r.result_code = RES_UART;
            end
         default: ;
      endcase
      r.driver_enable = (phase == PH_TURN || phase == PH_TX);
      expected_rsp.push_back(r);
   endfunction

   function bit check(rsp_type got, output string why);
      rsp_type want;
      why = "";
      if (expected_rsp.size() == 0) begin
         why = "response beat with nothing expected";
         return 1'b0;
      end
      want = expected_rsp.pop_front();
      if (got.driver_enable != want.driver_enable)
         why = {why, $sformatf(" driver_enable %0d/%0d", got.driver_enable, want.driver_enable)};
      if (got.start_transmit != want.start_transmit)
         why = {why, $sformatf(" start_transmit %0d/%0d", got.start_transmit, want.start_transmit)};
      if (got.abort_uart != want.abort_uart)
         why = {why, $sformatf(" abort_uart %0d/%0d", got.abort_uart, want.abort_uart)};
      if (got.byte_valid != want.byte_valid)
         why = {why, $sformatf(" byte_valid %0d/%0d", got.byte_valid, want.byte_valid)};
      if (got.byte_index != want.byte_index)
         why = {why, $sformatf(" byte_index %0d/%0d", got.byte_index, want.byte_index)};
      if (got.byte_data != want.byte_data)
         why = {why, $sformatf(" byte_data %0d/%0d", got.byte_data, want.byte_data)};
      if (got.done_res != want.done_res)
         why = {why, $sformatf(" done_res %0d/%0d", got.done_res, want.done_res)};
      if (got.result_code != want.result_code)
         why = {why, $sformatf(" result_code %0d/%0d", got.result_code, want.result_code)};
      if (got.receive_length != want.receive_length)
         why = {why, $sformatf(" receive_length %0d/%0d", got.receive_length,
                               want.receive_length)};
      return why == "";
   endfunction
endclass

module tb;

   // kinds of transaction the stimulus walks through
   localparam int F_TXERR     = 0;
   localparam int F_TXTIMEOUT = 1;
   localparam int F_NOREPLY   = 2;
   localparam int F_FIRSTERR  = 3;
   localparam int F_RXERR     = 5;

   localparam longint CYCLE_LIMIT = 64'd500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = MODE_TICK;
   logic [8:0]  req_request_length = '0;
   logic [7:0]  req_rx_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_BAUD;
   logic [15:0] csr_write_data = '0;
   wire rsp_type rsp_beat;

   rtu_scoreboard sb = new();

   int     errors = 0;
   int     frames = 0;
   int     bytes_seen = 0;
   int     ends_ok = 0;
   int     ends_uart = 0;
   int     ends_timeout = 0;
   int     tick_max = 20;      // most ticks between two reply bytes
   longint cycles = 0;
   bit     idle_on = 1'b1;     // random gaps on both sides
   bit     hold_request = 1'b0;

   rs485_rtu_master_transaction_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_request_length (req_request_length),
      .req_rx_data        (req_rx_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_driver_enable  (rsp_beat.driver_enable),
      .rsp_start_transmit (rsp_beat.start_transmit),
      .rsp_abort_uart     (rsp_beat.abort_uart),
      .rsp_byte_valid     (rsp_beat.byte_valid),
      .rsp_byte_index     (rsp_beat.byte_index),
      .rsp_byte_data      (rsp_beat.byte_data),
      .rsp_done_res       (rsp_beat.done_res),
      .rsp_result_code    (rsp_beat.result_code),
      .rsp_receive_length (rsp_beat.receive_length),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // watchdog, far above the cycles the whole run needs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb: errors");
         $finish;
      end
   end

   task automatic report(input string why);
      errors++;
      $display("mismatch at %0t:%s", $realtime, why);
   endtask

   // one event beat; inputs move on the falling edge, acceptance seen on the rising edge
   task automatic send(input logic [2:0] mode, input logic [8:0] len, input logic [7:0] data);
      int gap;
      gap = idle_on ? $urandom_range(11, 0) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode = mode;
      req_request_length = len;
      req_rx_data = data;
      do @(posedge clock); while (req_stall);
      sb.note_item(mode, len, data);
   endtask

   task automatic tick();
      send(MODE_TICK, 9'($urandom), 8'($urandom));
   endtask

   // tick without gaps until the transaction closes on its own timer
   task automatic run_out();
      bit saved;
      saved = idle_on;
      idle_on = 1'b0;
      while (sb.phase != PH_IDLE) tick();
      idle_on = saved;
   endtask

   // let every expected beat come back, then leave room for a start still in the divider
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      settle();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.write_csr(idx, value);
   endtask

   task automatic set_config(input logic [2:0] baud, input logic [1:0] fmt,
                             input logic [15:0] resp);
      write_reg(CSR_BAUD, 16'(baud));
      write_reg(CSR_FORMAT, 16'(fmt));
      write_reg(CSR_RESP_TO, resp);
   endtask

   // one whole exchange, with stray events mixed in where they should be ignored
   task automatic frame(input logic [8:0] len, input int kind, input int nbytes);
      frames++;
      send(MODE_START, len, 8'($urandom));
      if ($urandom_range(1, 0)) begin
         // start while busy, errors and stray events during turnaround
         send(MODE_START, 9'($urandom), 8'($urandom));
         send(MODE_ERROR, 9'($urandom), 8'($urandom));
         send(MODE_TX_DONE, 9'($urandom), 8'($urandom));
         send(MODE_RX_BYTE, 9'($urandom), 8'($urandom));
         send(3'($urandom_range(7, 5)), 9'($urandom), 8'($urandom));
      end
      while (sb.phase == PH_TURN) tick();
      if (kind == F_TXERR) begin
         repeat ($urandom_range(5, 0)) tick();
         send(MODE_ERROR, 9'($urandom), 8'($urandom));
         return;
      end
      if (kind == F_TXTIMEOUT) begin
         run_out();
         return;
      end
      repeat ($urandom_range(3, 0)) tick();
      send(MODE_TX_DONE, 9'($urandom), 8'($urandom));
      if (sb.phase == PH_IDLE) return;   // zero response timeout
      case (kind)
         F_NOREPLY: run_out();
         F_FIRSTERR: begin
            repeat ($urandom_range(20, 0)) tick();
            send(MODE_ERROR, 9'($urandom), 8'($urandom));
         end
         default: begin
            repeat ($urandom_range(20, 0)) tick();
            for (int i = 0; i < nbytes; i++) begin
               send(MODE_RX_BYTE, 9'($urandom), 8'($urandom));
               if ($urandom_range(7, 0) == 0) send(MODE_START, 9'($urandom), 8'($urandom));
               if ($urandom_range(7, 0) == 0) send(MODE_TX_DONE, 9'($urandom), 8'($urandom));
               repeat ($urandom_range(tick_max, 0)) tick();
            end
            if (kind == F_RXERR) send(MODE_ERROR, 9'($urandom), 8'($urandom));
            else run_out();
         end
      endcase
   endtask

   // response side: random stall per beat, plus one long hold-off on request
   always begin
      int n;
      @(negedge clock);
      if (hold_request) begin
         rsp_stall = 1'b1;
         repeat (400) @(negedge clock);
         hold_request = 1'b0;
      end
      n = idle_on ? $urandom_range(11, 0) : 0;
      if (n > 0) begin
         rsp_stall = 1'b1;
         repeat (n) @(negedge clock);
      end
      rsp_stall = 1'b0;
      do @(posedge clock); while (!rsp_valid || reset);
      begin
         string why;
         if (!sb.check(rsp_beat, why)) report(why);
      end
      if (rsp_beat.byte_valid) bytes_seen++;
      if (rsp_beat.done_res) begin
         case (rsp_beat.result_code)
            RES_OK:      ends_ok++;
            RES_UART:    ends_uart++;
            RES_TIMEOUT: ends_timeout++;
            default: ;
         endcase
      end
   end

   initial begin
      int kind;
      logic [15:0] resp;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: stray events in idle, then error endings at 9600 8n1
      send(3'd5, 9'h1ff, 8'hff);
      send(3'd6, 9'h000, 8'h00);
      send(3'd7, 9'h155, 8'haa);
      send(MODE_ERROR, 9'h0aa, 8'h55);
      send(MODE_TICK, 9'h000, 8'h00);
      send(MODE_TX_DONE, 9'h000, 8'h00);
      send(MODE_RX_BYTE, 9'h000, 8'hff);
      frame(9'd0, F_TXERR, 0);
      frame(9'd256, F_RXERR, 3);
      frame(9'd511, F_FIRSTERR, 0);

      // fastest rate, 11-bit characters, no first-byte wait; then an overfull reply
      set_config(3'd7, 2'd3, 16'd0);
      frame(9'd1, F_NOREPLY, 0);
      set_config(3'd7, 2'd3, 16'd2);
      tick_max = 1;
      frame(9'd100, F_RXERR, 260);   // bytes past the frame size are dropped
      tick_max = 20;

      // longest response timeout, receiver holds off while bytes keep coming
      set_config(3'd5, 2'd2, 16'hffff);
      hold_request = 1'b1;
      frame(9'd12, F_RXERR, 12);

      // random transactions under random settings
      for (int f = 0; f < 2; f++) begin
         resp = ($urandom_range(1, 0)) ? 16'd0 : 16'($urandom);
         set_config(3'($urandom), 2'($urandom), resp);
         case ($urandom_range(3, 0))
            0:       kind = F_TXERR;
            1:       kind = (sb.resp_ms == 16'd0) ? F_NOREPLY : F_FIRSTERR;
            default: kind = F_RXERR;
         endcase
         frame(9'($urandom), kind, $urandom_range(6, 1));
         if ($urandom_range(3, 0) == 0) send(3'($urandom_range(7, 5)), 9'($urandom),
                                             8'($urandom));
      end

      settle();
      $display("tb: %0d transactions, %0d response bytes", frames, bytes_seen);
      $display("tb: endings ok %0d, uart error %0d, slave timeout %0d",
               ends_ok, ends_uart, ends_timeout);
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
